// File: sv/slab_slot_allocator_macros.svh
// assertion helpers shared by the checker
`ifndef SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication on the block clock
`define SSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ssa_pkg.sv
`default_nettype none

package ssa_pkg;

  localparam int unsigned SLOTS_PER_BLOCK = 512;
  localparam int unsigned NUM_BLOCKS      = 64;

  localparam int unsigned BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_BLOCK);

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// File: sv/ssa_if.sv
`default_nettype none

interface ssa_in_if #(
  parameter int unsigned BLK_W  = ssa_pkg::BLK_W,
  parameter int unsigned SLOT_W = ssa_pkg::SLOT_W
);
  logic              valid;
  logic              ready;
  logic              mode;
  logic [BLK_W-1:0]  release_block;
  logic [SLOT_W-1:0] release_slot;

  modport source (output valid, mode, release_block, release_slot, input ready);
  modport sink   (input valid, mode, release_block, release_slot, output ready);
endinterface

interface ssa_out_if #(
  parameter int unsigned BLK_W  = ssa_pkg::BLK_W,
  parameter int unsigned SLOT_W = ssa_pkg::SLOT_W
);
  logic              valid;
  logic              ready;
  logic              status;
  logic [BLK_W-1:0]  granted_block;
  logic [SLOT_W-1:0] granted_slot;

  modport source (output valid, status, granted_block, granted_slot, input ready);
  modport sink   (input valid, status, granted_block, granted_slot, output ready);
endinterface

`default_nettype wire

// File: sv/slab_slot_allocator.sv
// Slab slot allocator: hands out slots named as (block, slot) from a pool of
// NUM_BLOCKS blocks of SLOTS_PER_BLOCK slots each.
// req_i (valid/ready): mode 0 allocates, mode 1 releases release_block/slot.
// rsp_o (valid/ready): one item per request; status 1 means every block is
// full, granted_block/granted_slot carry the slot on a successful allocate.
// Per-block head and count sit in one memory, free-list links in a second,
// the stack of non-full blocks in a third; all have registered reads.
// After acceptance, a release passes S_BLK and an allocate that opens a new
// block or fails passes S_OPEN before its result is loaded; an allocate from
// the stack top with an empty free list passes S_STK then S_BLK, and one that
// follows the free list passes S_STK, S_BLK and S_LNK.
// One item at a time: the next item is taken in the cycle after its
// predecessor's result is loaded, so the item rate is set by the chain of
// dependent reads stack -> block head -> link.
// Reset clears the control state only; blocks are opened in order and an
// unopened block is treated as empty, so no clearing pass is needed.
// A stalled result waits in the output register while the next item is
// accepted; that item then holds in its last step until the register frees.
`default_nettype none

module slab_slot_allocator #(
  parameter int unsigned SLOTS_PER_BLOCK = ssa_pkg::SLOTS_PER_BLOCK,
  parameter int unsigned NUM_BLOCKS      = ssa_pkg::NUM_BLOCKS
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ssa_in_if.sink    req_i,
  ssa_out_if.source rsp_o
);

  localparam int unsigned BLK_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned SLOT_W    = $clog2(SLOTS_PER_BLOCK);
  localparam int unsigned CNT_W     = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int unsigned FILL_W    = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LINK_W    = SLOT_W + 1;
  localparam int unsigned LADDR_W   = BLK_W + SLOT_W;
  localparam int unsigned LDEPTH    = NUM_BLOCKS << SLOT_W;
  localparam int unsigned BWORD_W   = LINK_W + CNT_W;
  localparam logic [LINK_W-1:0] LINK_NULL = '1;
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS_PER_BLOCK);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(NUM_BLOCKS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OPEN = 5'b00010,
    S_STK  = 5'b00100,
    S_BLK  = 5'b01000,
    S_LNK  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic              mode_q, mode_d;
  logic              rel_ok_q, rel_ok_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] opened_q, opened_d;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q;
  logic [BLK_W-1:0]  out_blk_q;
  logic [SLOT_W-1:0] out_slot_q;

  // block memory: {head, count}
  logic [BWORD_W-1:0] blk_mem [NUM_BLOCKS];
  logic [BWORD_W-1:0] blk_rdata_q;
  logic               blk_re, blk_we;
  logic [BLK_W-1:0]   blk_raddr, blk_waddr;
  logic [BWORD_W-1:0] blk_wdata;

  logic [LINK_W-1:0]  link_mem [LDEPTH];
  logic [LINK_W-1:0]  link_rdata_q;
  logic               link_re, link_we;
  logic [LADDR_W-1:0] link_raddr, link_waddr;
  logic [LINK_W-1:0]  link_wdata;

  logic [BLK_W-1:0]   stk_mem [NUM_BLOCKS];
  logic [BLK_W-1:0]   stk_rdata_q;
  logic               stk_re, stk_we;
  logic [BLK_W-1:0]   stk_raddr, stk_waddr;
  logic [BLK_W-1:0]   stk_wdata;

  logic [LINK_W-1:0]  head;
  logic [CNT_W-1:0]   cnt;
  logic [FILL_W-1:0]  fill_dec;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic               accept;
  logic               can_emit;
  logic               emit;
  logic               emit_status;
  logic [BLK_W-1:0]   emit_blk;
  logic [SLOT_W-1:0]  emit_slot;

  assign {head, cnt} = blk_rdata_q;
  assign fill_dec    = fill_q - 1'b1;
  assign cnt_inc     = cnt + 1'b1;
  assign cnt_dec     = cnt - 1'b1;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign can_emit    = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (blk_re) begin
      blk_rdata_q <= blk_mem[blk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    rel_ok_d    = rel_ok_q;
    blk_d       = blk_q;
    rslot_d     = rslot_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    opened_d    = opened_q;
    blk_re      = 1'b0;
    blk_raddr   = blk_q;
    blk_we      = 1'b0;
    blk_waddr   = blk_q;
    blk_wdata   = {LINK_NULL, cnt_q};
    link_re     = 1'b0;
    link_raddr  = {blk_q, head[SLOT_W-1:0]};
    link_we     = 1'b0;
    link_waddr  = {blk_q, rslot_q};
    link_wdata  = head;
    stk_re      = 1'b0;
    stk_raddr   = fill_dec[BLK_W-1:0];
    stk_we      = 1'b0;
    stk_waddr   = fill_q[BLK_W-1:0];
    stk_wdata   = blk_q;
    emit        = 1'b0;
    emit_status = ssa_pkg::STATUS_DONE;
    emit_blk    = '0;
    emit_slot   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d   = req_i.mode;
          blk_d    = req_i.release_block;
          rslot_d  = req_i.release_slot;
          rel_ok_d = (FILL_W'(req_i.release_block) < opened_q) &&
                     (CNT_W'(req_i.release_slot) < CNT_FULL);
          if (req_i.mode == ssa_pkg::MODE_ALLOC) begin
            if (fill_q == '0) begin
              state_d = S_OPEN;
            end else begin
              stk_re  = 1'b1;
              state_d = S_STK;
            end
          end else begin
            blk_re    = 1'b1;
            blk_raddr = req_i.release_block;
            state_d   = S_BLK;
          end
        end
      end
      S_OPEN: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (opened_q == FILL_MAX) begin
            emit_status = ssa_pkg::STATUS_FULL;
          end else begin
            blk_we    = 1'b1;
            blk_waddr = opened_q[BLK_W-1:0];
            blk_wdata = {LINK_NULL, CNT_W'(1)};
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = opened_q[BLK_W-1:0];
            fill_d    = FILL_W'(1);
            opened_d  = opened_q + 1'b1;
            emit_blk  = opened_q[BLK_W-1:0];
          end
        end
      end
      S_STK: begin
        blk_d     = stk_rdata_q;
        blk_re    = 1'b1;
        blk_raddr = stk_rdata_q;
        state_d   = S_BLK;
      end
      S_BLK: begin
        if (mode_q == ssa_pkg::MODE_ALLOC) begin
          if (head == LINK_NULL) begin
            if (can_emit) begin
              emit      = 1'b1;
              emit_blk  = blk_q;
              emit_slot = cnt[SLOT_W-1:0];
              blk_we    = 1'b1;
              blk_wdata = {LINK_NULL, cnt_inc};
              if (cnt_inc >= CNT_FULL) begin
                fill_d = fill_dec;
              end
              state_d = S_IDLE;
            end
          end else begin
            link_re = 1'b1;
            slot_d  = head[SLOT_W-1:0];
            cnt_d   = cnt_inc;
            state_d = S_LNK;
          end
        end else if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (rel_ok_q && (cnt != '0)) begin
            link_we   = 1'b1;
            blk_we    = 1'b1;
            blk_wdata = {(cnt_dec == '0) ? LINK_NULL : {1'b0, rslot_q}, cnt_dec};
            if ((cnt >= CNT_FULL) && (fill_q < FILL_MAX)) begin
              stk_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end
        end
      end
      S_LNK: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_blk  = blk_q;
          emit_slot = slot_q;
          blk_we    = 1'b1;
          blk_wdata = {link_rdata_q, cnt_q};
          if (cnt_q >= CNT_FULL) begin
            fill_d = fill_dec;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      opened_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      opened_q    <= opened_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    rel_ok_q <= rel_ok_d;
    blk_q    <= blk_d;
    rslot_q  <= rslot_d;
    slot_q   <= slot_d;
    cnt_q    <= cnt_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_blk_q    <= emit_blk;
      out_slot_q   <= emit_slot;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_block = out_blk_q;
  assign rsp_o.granted_slot  = out_slot_q;

endmodule

`default_nettype wire

// File: sv/ssa_checker.sv
`default_nettype none

`include "slab_slot_allocator_macros.svh"

module ssa_checker #(
  parameter int unsigned BLK_W  = ssa_pkg::BLK_W,
  parameter int unsigned SLOT_W = ssa_pkg::SLOT_W
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_i,
  input wire              out_valid_i,
  input wire              out_ready_i,
  input wire              out_status_i,
  input wire [BLK_W-1:0]  out_block_i,
  input wire [SLOT_W-1:0] out_slot_i
);

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  `SSA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result dropped while stalled")

  `SSA_ASSERT_NEXT(a_out_stable, out_stall,
    $stable(out_status_i) && $stable(out_block_i) && $stable(out_slot_i),
    "result changed while stalled")

  `SSA_ASSERT_NOW(a_fail_zero, out_valid_i && (out_status_i == ssa_pkg::STATUS_FULL),
    (out_block_i == '0) && (out_slot_i == '0), "failed allocate carries a slot")

  `SSA_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i,
    "item accepted while previous one in flight")

endmodule

bind slab_slot_allocator ssa_checker #(
  .BLK_W  (BLK_W),
  .SLOT_W (SLOT_W)
) u_ssa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_block_i  (rsp_o.granted_block),
  .out_slot_i   (rsp_o.granted_slot)
);

`default_nettype wire

// File: sim/slab_slot_allocator_test.sv
`timescale 1ns / 1ps

module slab_slot_allocator_test;

  localparam int unsigned LINK_W      = ssa_pkg::SLOT_W + 1;
  localparam logic [LINK_W-1:0] LINK_NONE = '1;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MIXED_ITEMS = 250;
  localparam int unsigned REUSE_ITEMS = 130;

  typedef logic [ssa_pkg::BLK_W-1:0]  blk_t;
  typedef logic [ssa_pkg::SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic  status;
    blk_t  blk;
    slot_t slot;
  } grant_t;

  typedef struct packed {
    blk_t  blk;
    slot_t slot;
  } slot_ref_t;

  typedef struct packed {
    logic   mode;
    blk_t   blk;
    slot_t  slot;
    logic   typed;
    grant_t grant;
  } stim_row_t;

  localparam grant_t NO_GRANT = '{ssa_pkg::STATUS_DONE, '0, '0};

  localparam stim_row_t DIRECTED [22] = '{
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd63, 9'd511, 1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd1,  9'd0,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd63, 9'd511, 1'b0, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd1,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd511, 1'b1, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd0,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd1,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd2,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd511, 1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd3,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd1,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd0,  9'd1,   1'b1, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_ALLOC,   6'd0,  9'd0,   1'b0, NO_GRANT},
    '{ssa_pkg::MODE_RELEASE, 6'd32, 9'd256, 1'b1, NO_GRANT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ssa_in_if  req ();
  ssa_out_if rsp ();

  slab_slot_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // allocator state as seen by the predictor
  logic [LINK_W-1:0]         link_mem [ssa_pkg::NUM_BLOCKS][ssa_pkg::SLOTS_PER_BLOCK];
  logic [LINK_W-1:0]         head_of [ssa_pkg::NUM_BLOCKS];
  logic [ssa_pkg::SLOT_W:0]  in_use [ssa_pkg::NUM_BLOCKS];
  blk_t                      open_blocks [ssa_pkg::NUM_BLOCKS];
  logic [ssa_pkg::BLK_W:0]   open_depth;
  logic [ssa_pkg::BLK_W:0]   opened;

  grant_t    pending_grants [$];
  slot_ref_t live_slots [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_taken;
  int unsigned n_granted;
  int unsigned n_refused;
  int unsigned n_released;
  int unsigned burst_left;
  int unsigned idle_cycles;

  function automatic grant_t grant_for(input logic m, input blk_t b, input slot_t s);
    grant_t              g;
    blk_t                top;
    logic [LINK_W-1:0]   pick;
    g = NO_GRANT;
    if (m == ssa_pkg::MODE_ALLOC) begin
      if (open_depth == 0) begin
        if (opened >= ssa_pkg::NUM_BLOCKS) begin
          g.status = ssa_pkg::STATUS_FULL;
          return g;
        end
        open_blocks[0] = blk_t'(opened);
        open_depth = (ssa_pkg::BLK_W + 1)'(1);
        opened++;
      end
      top = open_blocks[open_depth - 1];
      if (head_of[top] == LINK_NONE) begin
        pick = in_use[top];
      end else begin
        pick = head_of[top];
        head_of[top] = link_mem[top][pick[ssa_pkg::SLOT_W-1:0]];
      end
      in_use[top]++;
      if (in_use[top] >= ssa_pkg::SLOTS_PER_BLOCK) begin
        open_depth--;
      end
      g.blk  = top;
      g.slot = pick[ssa_pkg::SLOT_W-1:0];
    end else if (b < opened && in_use[b] != 0) begin
      if (in_use[b] >= ssa_pkg::SLOTS_PER_BLOCK && open_depth < ssa_pkg::NUM_BLOCKS) begin
        open_blocks[open_depth] = b;
        open_depth++;
      end
      link_mem[b][s] = head_of[b];
      head_of[b] = {1'b0, s};
      in_use[b]--;
      if (in_use[b] == 0) begin
        head_of[b] = LINK_NONE;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic send_item(input logic m, input blk_t b, input slot_t s, input logic typed,
                           input grant_t typed_grant);
    grant_t    g;
    slot_ref_t r;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    req.valid         <= 1'b1;
    req.mode          <= m;
    req.release_block <= b;
    req.release_slot  <= s;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    burst_left--;
    items_taken++;
    g = grant_for(m, b, s);
    pending_grants.insert(pending_grants.size(), typed ? typed_grant : g);
    if (m == ssa_pkg::MODE_RELEASE) begin
      n_released++;
    end else if (g.status == ssa_pkg::STATUS_FULL) begin
      n_refused++;
    end else begin
      n_granted++;
      r.blk  = g.blk;
      r.slot = g.slot;
      live_slots.insert(live_slots.size(), r);
    end
  endtask

  task automatic random_step(input int unsigned release_pct);
    int unsigned roll;
    int unsigned k;
    slot_ref_t   r;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // arbitrary release: any block and slot, opened or not, in use or not
      send_item(ssa_pkg::MODE_RELEASE, blk_t'($urandom), slot_t'($urandom), 1'b0, NO_GRANT);
    end else if (roll < 8 + release_pct && live_slots.size() != 0) begin
      k = $urandom_range(0, live_slots.size() - 1);
      r = live_slots[k];
      live_slots.delete(k);
      send_item(ssa_pkg::MODE_RELEASE, r.blk, r.slot, 1'b0, NO_GRANT);
    end else begin
      send_item(ssa_pkg::MODE_ALLOC, blk_t'($urandom), slot_t'($urandom), 1'b0, NO_GRANT);
    end
  endtask

  task automatic wait_all_results();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_grants.pop_front();
        if (rsp.status !== want.status) begin
          report_mismatch("status", rsp.status, want.status);
        end
        if (rsp.granted_block !== want.blk) begin
          report_mismatch("granted_block", rsp.granted_block, want.blk);
        end
        if (rsp.granted_slot !== want.slot) begin
          report_mismatch("granted_slot", rsp.granted_slot, want.slot);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results pending", idle_cycles,
               pending_grants.size());
      $display("slab_slot_allocator regression: fail");
      $finish;
    end
  end

  // receiver: random stall segments plus one long hold-off
  initial begin : drive_ready
    int unsigned seg_left;
    int unsigned style;
    int unsigned stall_left;
    bit          hold_done;
    rsp.ready  = 1'b0;
    seg_left   = 0;
    style      = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_taken >= 60) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 64);
        style    = $urandom_range(0, 2);
      end
      seg_left--;
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (style)
          0: begin
            rsp.ready <= 1'b1;
          end
          1: begin
            rsp.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            rsp.ready <= (seg_left % 4 == 0);
          end
        endcase
      end
    end
  end

  initial begin : run_stimulus
    stim_row_t row;
    rst_ni            = 1'b0;
    req.valid         = 1'b0;
    req.mode          = ssa_pkg::MODE_ALLOC;
    req.release_block = '0;
    req.release_slot  = '0;
    mismatches        = 0;
    results_seen      = 0;
    items_taken       = 0;
    n_granted         = 0;
    n_refused         = 0;
    n_released        = 0;
    burst_left        = 0;
    idle_cycles       = 0;
    for (int b = 0; b < ssa_pkg::NUM_BLOCKS; b++) begin
      head_of[b] = LINK_NONE;
      in_use[b]  = '0;
    end
    open_depth = '0;
    opened     = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_item(row.mode, row.blk, row.slot, row.typed, row.grant);
    end
    wait_all_results();

    // alternate windows that grow and shrink the pool
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      random_step(((i / 50) % 2 == 1) ? 70 : 25);
    end
    wait_all_results();

    // release-heavy tail that drains blocks and reuses freed slots
    for (int i = 0; i < REUSE_ITEMS; i++) begin
      random_step(60);
    end
    wait_all_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d grants, %0d refusals, %0d releases incl. stray and repeated ones",
             n_granted, n_refused, n_released);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("slab_slot_allocator regression: pass");
    end else begin
      $display("slab_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/ssa_pkg.sv
sv/ssa_if.sv
sv/slab_slot_allocator.sv
sv/ssa_checker.sv
sim/slab_slot_allocator_test.sv
